/* design/atsc_pkg.sv */
// Package for the adaptive time step controller: constants and sizes.
// No dependencies.
`timescale 1ns / 1ps
package atsc_pkg;
    localparam int TIME_W_DEF = 32;
    localparam int FRAC_W_DEF = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SPO_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_INTV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPO       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL       = 2'd3;

    localparam logic [31:0] RST_INIT_STEP = 32'd655;
    localparam logic [31:0] RST_OUT_INTV  = 32'd6554;
    localparam logic [15:0] RST_SPO       = 16'd1;
    localparam logic [31:0] RST_TOL       = 32'd655;

    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;
endpackage

/* design/atsc_if.sv */
// Valid/ready channel interfaces for the controller.
// No dependencies.
`timescale 1ns / 1ps
interface atsc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] residual;
    modport source (output valid, action, residual, input ready);
    modport sink   (input valid, action, residual, output ready);
endinterface

interface atsc_out_if;
    logic        valid;
    logic        ready;
    logic        output_due;
    logic [31:0] output_number;
    logic [31:0] step_number;
    logic [31:0] time_now;
    logic [31:0] step_now;
    modport source (output valid, output_due, output_number, step_number, time_now,
                    step_now, input ready);
    modport sink   (input valid, output_due, output_number, step_number, time_now,
                    step_now, output ready);
endinterface

interface atsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/adaptive_time_step_controller.sv */
// Top level of the adaptive time step controller: sequencer, state and config.
// Depends on atsc_pkg, atsc_if and atsc_div.
`timescale 1ns / 1ps
// Usage:
//   cfg: write channel, index 0 initial step (also loads the step), 1 output
//        interval (0 = step-count mode), 2 steps per output, 3 tolerance.
//        Write only while idle. ready is always high.
//   in : one word per item, action 0 = advance, 1 = update from residual.
//   out: one word per item with output flag, indexes, time and step size.
// Divisions: all run through one shared 64-bit radix-2 divider. The first
//   realign division starts in S_FIN, after the rescale if any; the
//   second starts in the done cycle of the first. An advance takes one
//   division, as does an update in step-count mode; an update in interval
//   mode takes three (rescale, rounded step count, realigned step). A zero
//   residual skips the rescale. The fifth-of-step floor is a reciprocal
//   multiply, no division.
// Flow: one item in flight; in.ready is high only while idle, so a new item
//   is not taken until the result word of the last one has been taken.
// Reset: time, step count and output index clear, step takes 655, registers
//   take their documented defaults. A stalled receiver holds the result word
//   and the block accepts nothing further until it is taken.
module adaptive_time_step_controller #(
    parameter int TIME_WIDTH = atsc_pkg::TIME_W_DEF
) (
    input  logic clk,
    input  logic rst_n,
    atsc_cfg_if.sink  cfg,
    atsc_in_if.sink   in,
    atsc_out_if.source out
);
    import atsc_pkg::*;
    localparam int DW = 2 * TIME_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TMAX = '1;
    // floor(x / 5) = (x * RECIP5) >> 34 for any x below 2^32
    localparam logic [63:0] RECIP5 = 64'hCCCC_CCCD;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ADV   = 9'b000000010,
        S_ADVW  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_RESW  = 9'b000010000,
        S_NW    = 9'b000100000,
        S_NDW   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [TIME_WIDTH-1:0] intv_reg, tol_reg;
    logic [SPO_W-1:0]      spo_reg;
    logic [TIME_WIDTH-1:0] time_reg, time_next, step_reg, step_next;
    logic [31:0]           cnt_reg, cnt_next, oidx_reg, oidx_next;
    logic                  flag_reg, flag_next, due_reg, due_next;
    logic                  act_reg;
    logic [31:0]           res_reg;
    logic [TIME_WIDTH-1:0] till_reg, till_next, nd;
    logic [DW-1:0]         prod_reg, prod_next;

    logic                  div_start;
    logic [DW-1:0]         dvd, dvs, quo, rem;
    logic                  ddone;

    logic [TIME_WIDTH:0]   tsum;
    logic [DW-1:0]         target;
    logic [DW-1:0]         nq;
    logic [63:0]           fifth_prod;
    logic [TIME_WIDTH-1:0] fifth;

    atsc_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
        .done(ddone), .quotient(quo), .remainder(rem)
    );

    assign cfg.ready = 1'b1;
    assign in.ready  = (state_reg == S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.output_due    = due_reg;
    assign out.output_number = oidx_reg;
    assign out.step_number   = cnt_reg;
    assign out.time_now      = 32'(time_reg);
    assign out.step_now      = 32'(step_reg);

    always_comb
    begin
        state_next = state_reg;
        time_next = time_reg; step_next = step_reg; cnt_next = cnt_reg;
        oidx_next = oidx_reg; flag_next = flag_reg; due_next = due_reg;
        till_next = till_reg; prod_next = prod_reg;
        div_start = 1'b0; dvd = '0; dvs = '1;
        tsum = {1'b0, time_reg} + {1'b0, step_reg};
        // next output boundary, (index + 1) * interval without wrapping the index
        target = DW'(oidx_reg) * DW'(intv_reg) + DW'(intv_reg);
        fifth_prod = 64'(step_reg) * RECIP5;
        fifth = TIME_WIDTH'(fifth_prod[63:34]);
        nq = '0;
        nd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in.valid)
                    state_next = (in.action == ACT_UPDATE) ? S_MUL : S_ADV;
            end
            S_ADV:
            begin
                time_next = tsum[TIME_WIDTH] ? TMAX : tsum[TIME_WIDTH-1:0];
                cnt_next = cnt_reg + 32'd1;
                div_start = 1'b1;
                if (intv_reg != '0)
                begin
                    dvd = (DW'(time_next) << 1) + DW'(step_reg);
                    dvs = DW'(intv_reg) << 1;
                end
                else
                begin
                    dvd = DW'(cnt_next);
                    dvs = (spo_reg == '0) ? DW'(1) : DW'(spo_reg);
                end
                state_next = S_ADVW;
            end
            S_ADVW:
            begin
                if (ddone)
                begin
                    if (intv_reg != '0)
                    begin
                        nq = (quo > DW'(32'hFFFFFFFF)) ? DW'(32'hFFFFFFFF) : quo;
                        if (32'(nq) > oidx_reg)
                        begin
                            oidx_next = 32'(nq); flag_next = 1'b1;
                        end
                        else
                            flag_next = 1'b0;
                    end
                    else
                    begin
                        oidx_next = 32'(quo);
                        flag_next = (rem == '0);
                    end
                    due_next = flag_next;
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                due_next = 1'b0;
                prod_next = DW'(step_reg) * DW'(tol_reg);
                if (target[DW-1:0] > DW'(time_reg))
                begin
                    nq = target - DW'(time_reg);
                    till_next = (nq > DW'(TMAX)) ? TMAX : nq[TIME_WIDTH-1:0];
                end
                else
                    till_next = '0;
                if (res_reg == '0)
                begin
                    step_next = TMAX;
                    state_next = (intv_reg != '0) ? S_FIN : S_OUT;
                end
                else
                begin
                    div_start = 1'b1;
                    dvd = prod_next; dvs = DW'(res_reg);
                    state_next = S_RESW;
                end
            end
            S_RESW:
            begin
                if (ddone)
                begin
                    step_next = (quo > DW'(TMAX)) ? TMAX : quo[TIME_WIDTH-1:0];
                    state_next = (intv_reg != '0) ? S_FIN : S_OUT;
                end
            end
            S_FIN:
            begin
                div_start = 1'b1;
                dvd = (DW'(till_reg) << 1) + DW'(step_reg);
                dvs = (step_reg == '0) ? DW'(1) : (DW'(step_reg) << 1);
                state_next = S_NW;
            end
            S_NW:
            begin
                if (ddone)
                begin
                    nq = (step_reg == '0 || quo == '0) ? DW'(1) : quo;
                    div_start = 1'b1;
                    dvd = DW'(till_reg); dvs = nq;
                    state_next = S_NDW;
                end
            end
            S_NDW:
            begin
                if (ddone)
                begin
                    nd = quo[TIME_WIDTH-1:0];
                    if (nd >= step_reg)
                    begin
                        nq = DW'(step_reg) << 1;
                        if (DW'(nd) < nq)
                            step_next = nd;
                        else
                            step_next = (nq > DW'(TMAX)) ? TMAX : nq[TIME_WIDTH-1:0];
                    end
                    else
                        step_next = (nd > fifth) ? nd : fifth;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg.valid && cfg.index == REG_INIT_STEP)
            step_next = TIME_WIDTH'(cfg.data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            intv_reg <= TIME_WIDTH'(RST_OUT_INTV);
            spo_reg  <= RST_SPO;
            tol_reg  <= TIME_WIDTH'(RST_TOL);
            time_reg <= '0; step_reg <= TIME_WIDTH'(RST_INIT_STEP);
            cnt_reg <= '0; oidx_reg <= '0; flag_reg <= 1'b0; due_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg <= time_next; step_reg <= step_next; cnt_reg <= cnt_next;
            oidx_reg <= oidx_next; flag_reg <= flag_next; due_reg <= due_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_OUT_INTV:  intv_reg <= TIME_WIDTH'(cfg.data);
                    REG_SPO:       spo_reg  <= cfg.data[SPO_W-1:0];
                    REG_TOL:       tol_reg  <= TIME_WIDTH'(cfg.data);
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        till_reg <= till_next; prod_reg <= prod_next;
        if (in.valid && in.ready)
        begin
            act_reg <= in.action;
            res_reg <= in.residual;
        end
    end

`ifndef NO_ASSERTIONS
    // An advance always bumps the step count by one.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV) |=> (cnt_reg == $past(cnt_reg) + 32'd1))
        else $error("step count not incremented");
    // Update items never flag an output.
    a_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && act_reg == ACT_UPDATE) |-> !out.output_due)
        else $error("update flagged output");
    // Time never moves backward.
    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV) |=> (time_reg >= $past(time_reg)))
        else $error("time went backward");
    // The divider is never started while idle.
    a_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_start)
        else $error("divider started while idle");
`endif
endmodule

/* design/atsc_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on atsc_pkg.
`timescale 1ns / 1ps
module atsc_div #(
    parameter int W = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output logic                 done,
    output logic [W-1:0]         quotient,
    output logic [W-1:0]         remainder
);
    import atsc_pkg::*;
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next, d_reg, d_next;
    logic [W:0]    r_reg, r_next, trial;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        q_next = q_reg; d_next = d_reg; r_next = r_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = dividend; d_next = divisor; r_next = '0;
            cnt_next = CW'(W); busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
            if (!trial[W])
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; d_reg <= d_next; r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[W-1:0];
endmodule
